@@ design/video_display_host_port_and_line_timer_defines.svh @@
// assertion macros for the host port and line timer checker
`ifndef VIDEO_DISPLAY_HOST_PORT_AND_LINE_TIMER_DEFINES_SVH
`define VIDEO_DISPLAY_HOST_PORT_AND_LINE_TIMER_DEFINES_SVH

// property that holds at every clock edge outside reset
`define VDHP_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("vdhp port check failed");

// implication checked in the same cycle
`define VDHP_ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
    `VDHP_ASSERT(lbl, clk, rstn, (ante) |-> (cons))

`endif

@@ design/vdhp_pkg.sv @@
// shared types, codes and constants of the host port and line timer
`timescale 1ns / 1ps
package vdhp_pkg;

    // default sizes
    localparam int MEMORY_DEPTH_DEF    = 16384;
    localparam int CYCLES_PER_LINE_DEF = 228;
    localparam int VISIBLE_LINES_DEF   = 192;
    localparam int TOTAL_LINES_DEF     = 262;

    // fixed field widths
    localparam int ADDR_W = 14;
    localparam int CYC_W  = 9;
    localparam int LINE_W = 9;

    // transaction kinds
    localparam logic [2:0] KIND_CTRL_WRITE = 3'd0;
    localparam logic [2:0] KIND_DATA_WRITE = 3'd1;
    localparam logic [2:0] KIND_DATA_READ  = 3'd2;
    localparam logic [2:0] KIND_STATUS     = 3'd3;
    localparam logic [2:0] KIND_TICK       = 3'd4;
    localparam logic [2:0] KIND_TAKE_IRQ   = 3'd5;

    // bit constants
    localparam logic [7:0] REG1_FORCE   = 8'h80;
    localparam logic [7:0] STATUS_KEEP  = 8'h1F;
    localparam logic [5:0] ADDR_HI_MASK = 6'h3F;
    localparam logic [2:0] REG_IDX_ONE  = 3'd1;
    localparam int         IRQ_EN_BIT   = 5;
    localparam int         VBLANK_BIT   = 7;
    localparam int         CMD_REG_BIT  = 7;
    localparam int         CMD_NOPF_BIT = 6;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] port_byte;
        logic [7:0] tick_cycles;
    } t_in_item;

    typedef struct packed {
        logic [7:0]        read_value;
        logic              interrupt_taken;
        logic              interrupt_level;
        logic              line_done;
        logic [LINE_W-1:0] done_line_number;
        logic              last;
    } t_out_item;

    // line timer report for one tick
    typedef struct packed {
        logic              vblank;
        logic              first_done;
        logic              second_done;
        logic [LINE_W-1:0] first_line;
        logic [LINE_W-1:0] second_line;
    } t_tick_info;

    // memory port control
    typedef struct packed {
        logic we;
        logic re;
    } t_mem_ctl;

endpackage

@@ design/vdhp_ram.sv @@
// generic single-port ram with registered read
`timescale 1ns / 1ps
module vdhp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16384
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/vdhp_line_timer.sv @@
// cycle and scan line counters, at most two lines per tick
`timescale 1ns / 1ps
module vdhp_line_timer #(
    parameter int CYCLES_PER_LINE = vdhp_pkg::CYCLES_PER_LINE_DEF,
    parameter int VISIBLE_LINES   = vdhp_pkg::VISIBLE_LINES_DEF,
    parameter int TOTAL_LINES     = vdhp_pkg::TOTAL_LINES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_tick,
    input  logic [7:0]           i_tick_cycles,
    output vdhp_pkg::t_tick_info o_info
);
    import vdhp_pkg::*;

    localparam logic [CYC_W:0]    CPL       = (CYC_W+1)'(CYCLES_PER_LINE);
    localparam logic [LINE_W:0]   TOTAL     = (LINE_W+1)'(TOTAL_LINES);
    localparam logic [LINE_W-1:0] VBL_LINE  = LINE_W'(VISIBLE_LINES - 1);

    logic [CYC_W-1:0]  r_cycles;
    logic [LINE_W-1:0] r_line;
    logic [CYC_W-1:0]  n_cycles;
    logic [LINE_W-1:0] n_line;
    logic [CYC_W:0]    sum0;
    logic [CYC_W:0]    sum1;
    logic [CYC_W:0]    sum2;
    logic              hit1;
    logic              hit2;
    logic [LINE_W-1:0] line1;
    logic [LINE_W-1:0] line2;

    function automatic logic [LINE_W-1:0] next_line(input logic [LINE_W-1:0] l);
        logic [LINE_W:0] inc;
        inc = {1'b0, l} + (LINE_W+1)'(1);
        return (inc >= TOTAL) ? '0 : inc[LINE_W-1:0];
    endfunction

    // two compare and subtract steps
    always_comb begin
        sum0  = {1'b0, r_cycles} + (CYC_W+1)'(i_tick_cycles);
        hit1  = sum0 >= CPL;
        sum1  = hit1 ? (sum0 - CPL) : sum0;
        hit2  = hit1 && (sum1 >= CPL);
        sum2  = hit2 ? (sum1 - CPL) : sum1;
        line1 = next_line(r_line);
        line2 = next_line(line1);
        n_cycles = sum2[CYC_W-1:0];
        n_line   = hit2 ? line2 : (hit1 ? line1 : r_line);

        o_info.first_done  = i_tick && hit1;
        o_info.second_done = i_tick && hit2;
        o_info.first_line  = r_line;
        o_info.second_line = line1;
        o_info.vblank      = i_tick && ((hit1 && r_line == VBL_LINE)
                                     || (hit2 && line1 == VBL_LINE));
    end

    // counter state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cycles <= '0;
            r_line   <= '0;
        end else if (i_tick) begin
            r_cycles <= n_cycles;
            r_line   <= n_line;
        end
    end

endmodule

@@ design/vdhp_host_port.sv @@
// control, data and status port registers with video memory access
`timescale 1ns / 1ps
module vdhp_host_port #(
    parameter int MEMORY_DEPTH = vdhp_pkg::MEMORY_DEPTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    input  vdhp_pkg::t_in_item              i_item,
    input  vdhp_pkg::t_tick_info            i_tick,
    input  logic [7:0]                      i_mem_rdata,
    output vdhp_pkg::t_mem_ctl              o_mem_ctl,
    output logic [$clog2(MEMORY_DEPTH)-1:0] o_mem_addr,
    output logic [7:0]                      o_mem_wdata,
    output logic [7:0]                      o_read_value,
    output logic                            o_taken,
    output logic                            o_irq_level
);
    import vdhp_pkg::*;

    localparam int             AW    = $clog2(MEMORY_DEPTH);
    localparam logic [ADDR_W:0] DEPTH = (ADDR_W+1)'(MEMORY_DEPTH);

    logic [ADDR_W-1:0] r_addr;
    logic [7:0]        r_latch;
    logic              r_expect;
    logic [7:0]        r_read_ahead;
    logic              r_ra_from_mem;
    logic [7:0]        r_status;
    logic              r_pending;
    logic [7:0]        r_mode [8];

    logic [ADDR_W-1:0] n_addr;
    logic [7:0]        n_latch;
    logic              n_expect;
    logic [7:0]        n_read_ahead;
    logic              n_ra_from_mem;
    logic [7:0]        n_status;
    logic              n_pending;
    logic [7:0]        n_mode [8];

    logic [7:0]        ra_now;
    logic [ADDR_W-1:0] set_addr;
    logic [ADDR_W-1:0] mem_addr14;
    logic [ADDR_W-1:0] addr_inc;
    logic [7:0]        b;

    // fold a 14-bit address onto the memory depth (mirroring)
    function automatic logic [AW-1:0] fold(input logic [ADDR_W-1:0] a);
        logic [ADDR_W:0] v;
        v = {1'b0, a};
        for (int k = 0; k < 3; k++) begin
            if (v >= DEPTH) begin
                v = v - DEPTH;
            end
        end
        return v[AW-1:0];
    endfunction

    assign ra_now   = r_ra_from_mem ? i_mem_rdata : r_read_ahead;
    assign b        = i_item.port_byte;
    assign set_addr = {b[5:0] & ADDR_HI_MASK, r_latch};
    assign addr_inc = r_addr + ADDR_W'(1);

    // next state of the port registers
    always_comb begin
        n_addr        = r_addr;
        n_latch       = r_latch;
        n_expect      = r_expect;
        n_read_ahead  = ra_now;
        n_ra_from_mem = 1'b0;
        n_status      = r_status;
        n_pending     = r_pending;
        n_mode        = r_mode;
        mem_addr14    = r_addr;
        o_mem_ctl     = '0;
        o_mem_wdata   = b;
        o_read_value  = '0;
        o_taken       = 1'b0;
        if (i_valid) begin
            case (i_item.kind)
                KIND_CTRL_WRITE: begin
                    if (!r_expect) begin
                        n_latch  = b;
                        n_expect = 1'b1;
                    end else begin
                        n_expect = 1'b0;
                        if (b[CMD_REG_BIT]) begin
                            if (b[2:0] == REG_IDX_ONE) begin
                                n_mode[REG_IDX_ONE] = r_latch | REG1_FORCE;
                                if (r_latch[IRQ_EN_BIT] && r_status[VBLANK_BIT]) begin
                                    n_pending = 1'b1;
                                end
                            end else begin
                                n_mode[b[2:0]] = r_latch;
                            end
                        end else begin
                            n_addr = set_addr;
                            if (!b[CMD_NOPF_BIT]) begin
                                mem_addr14    = set_addr;
                                o_mem_ctl.re  = 1'b1;
                                n_ra_from_mem = 1'b1;
                                n_addr        = set_addr + ADDR_W'(1);
                            end
                        end
                    end
                end
                KIND_DATA_WRITE: begin
                    o_mem_ctl.we = 1'b1;
                    n_read_ahead = b;
                    n_addr       = addr_inc;
                    n_expect     = 1'b0;
                end
                KIND_DATA_READ: begin
                    o_read_value  = ra_now;
                    o_mem_ctl.re  = 1'b1;
                    n_ra_from_mem = 1'b1;
                    n_addr        = addr_inc;
                    n_expect      = 1'b0;
                end
                KIND_STATUS: begin
                    o_read_value = r_status;
                    n_status     = r_status & STATUS_KEEP;
                    n_expect     = 1'b0;
                end
                KIND_TICK: begin
                    if (i_tick.vblank) begin
                        n_status[VBLANK_BIT] = 1'b1;
                        if (r_mode[REG_IDX_ONE][IRQ_EN_BIT]) begin
                            n_pending = 1'b1;
                        end
                    end
                end
                KIND_TAKE_IRQ: begin
                    o_taken   = r_pending;
                    n_pending = 1'b0;
                end
                default: begin
                end
            endcase
        end
        o_irq_level = n_pending;
        o_mem_addr  = fold(mem_addr14);
    end

    // port register state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr        <= '0;
            r_latch       <= '0;
            r_expect      <= 1'b0;
            r_read_ahead  <= '0;
            r_ra_from_mem <= 1'b0;
            r_status      <= '0;
            r_pending     <= 1'b0;
            for (int k = 0; k < 8; k++) begin
                r_mode[k] <= (3'(k) == REG_IDX_ONE) ? REG1_FORCE : 8'h00;
            end
        end else begin
            r_addr        <= n_addr;
            r_latch       <= n_latch;
            r_expect      <= n_expect;
            r_read_ahead  <= n_read_ahead;
            r_ra_from_mem <= n_ra_from_mem;
            r_status      <= n_status;
            r_pending     <= n_pending;
            r_mode        <= n_mode;
        end
    end

endmodule

@@ design/video_display_host_port_and_line_timer.sv @@
// top level: host port and line timer of a video display processor
//
//  channel      handshake          payload
//  ----------   ----------------   --------------------------------
//  command in   start / busy       i_item   (kind, port_byte, tick_cycles)
//  result out   o_done (strobe)    o_result (read_value ... last)
//
// a transaction is taken into the input register, worked there and its result
// is held in the result register; one transaction per cycle while not busy.
// a tick that completes two lines sends two results and holds busy for one
// cycle. after reset busy stays high while the memory sweep writes zeros to
// every entry. results cannot be stalled by the receiver.
`timescale 1ns / 1ps
module video_display_host_port_and_line_timer #(
    parameter int MEMORY_DEPTH    = vdhp_pkg::MEMORY_DEPTH_DEF,
    parameter int CYCLES_PER_LINE = vdhp_pkg::CYCLES_PER_LINE_DEF,
    parameter int VISIBLE_LINES   = vdhp_pkg::VISIBLE_LINES_DEF,
    parameter int TOTAL_LINES     = vdhp_pkg::TOTAL_LINES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  vdhp_pkg::t_in_item  i_item,
    output logic                o_done,
    output vdhp_pkg::t_out_item o_result
);
    import vdhp_pkg::*;

    localparam int AW = $clog2(MEMORY_DEPTH);

    logic       r_in_valid;
    t_in_item   r_in;
    logic       r_clearing;
    logic [AW-1:0] r_clr_addr;
    logic       r_done;
    t_out_item  r_result;
    logic       r_hold_valid;
    t_out_item  r_hold;

    logic       accept;
    t_tick_info tick_info;
    t_mem_ctl   port_ctl;
    logic [AW-1:0] port_addr;
    logic [7:0] port_wdata;
    logic [7:0] mem_rdata;
    logic [7:0] read_value;
    logic       taken;
    logic       irq_level;
    logic       ram_we;
    logic       ram_re;
    logic [AW-1:0] ram_addr;
    logic [7:0] ram_wdata;
    t_out_item  res_first;
    t_out_item  res_second;

    assign busy   = r_clearing || tick_info.second_done;
    assign accept = start && !busy;

    vdhp_line_timer #(
        .CYCLES_PER_LINE (CYCLES_PER_LINE),
        .VISIBLE_LINES   (VISIBLE_LINES),
        .TOTAL_LINES     (TOTAL_LINES)
    ) u_timer (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_tick        (r_in_valid && r_in.kind == KIND_TICK),
        .i_tick_cycles (r_in.tick_cycles),
        .o_info        (tick_info)
    );

    vdhp_host_port #(
        .MEMORY_DEPTH (MEMORY_DEPTH)
    ) u_port (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (r_in_valid),
        .i_item       (r_in),
        .i_tick       (tick_info),
        .i_mem_rdata  (mem_rdata),
        .o_mem_ctl    (port_ctl),
        .o_mem_addr   (port_addr),
        .o_mem_wdata  (port_wdata),
        .o_read_value (read_value),
        .o_taken      (taken),
        .o_irq_level  (irq_level)
    );

    // memory port: clearing sweep has it until done
    assign ram_we    = r_clearing || port_ctl.we;
    assign ram_re    = !r_clearing && port_ctl.re;
    assign ram_addr  = r_clearing ? r_clr_addr : port_addr;
    assign ram_wdata = r_clearing ? 8'd0 : port_wdata;

    vdhp_ram #(
        .WIDTH (8),
        .DEPTH (MEMORY_DEPTH)
    ) u_vram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_re    (ram_re),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (mem_rdata)
    );

    // result words for the transaction in work
    always_comb begin
        res_first.read_value       = read_value;
        res_first.interrupt_taken  = taken;
        res_first.interrupt_level  = irq_level;
        res_first.line_done        = tick_info.first_done;
        res_first.done_line_number = tick_info.first_done ? tick_info.first_line : '0;
        res_first.last             = !tick_info.second_done;

        res_second.read_value       = '0;
        res_second.interrupt_taken  = 1'b0;
        res_second.interrupt_level  = irq_level;
        res_second.line_done        = 1'b1;
        res_second.done_line_number = tick_info.second_line;
        res_second.last             = 1'b1;
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= accept;
        end
        if (accept) begin
            r_in <= i_item;
        end
    end

    // clearing sweep after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            if (r_clr_addr == AW'(MEMORY_DEPTH - 1)) begin
                r_clearing <= 1'b0;
            end
            r_clr_addr <= r_clr_addr + AW'(1);
        end
    end

    // result register and second-line hold
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done       <= 1'b0;
            r_hold_valid <= 1'b0;
        end else if (r_hold_valid) begin
            r_done       <= 1'b1;
            r_result     <= r_hold;
            r_hold_valid <= 1'b0;
        end else if (r_in_valid) begin
            r_done       <= 1'b1;
            r_result     <= res_first;
            r_hold       <= res_second;
            r_hold_valid <= tick_info.second_done;
        end else begin
            r_done <= 1'b0;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

@@ design/vdhp_port_checker.sv @@
// port checker for the host port and line timer, bound to the top level
`timescale 1ns / 1ps
`include "video_display_host_port_and_line_timer_defines.svh"
module vdhp_port_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                start,
    input logic                busy,
    input logic                o_done,
    input vdhp_pkg::t_out_item o_result
);
    import vdhp_pkg::*;

    // each accepted transaction shows its first result after the input and result registers
    `VDHP_ASSERT(a_accept_to_result, i_clk, i_rst_n, (start && !busy) |-> ##2 o_done)

    // a result not marked last is followed at once by the closing one
    `VDHP_ASSERT(a_second_follows, i_clk, i_rst_n, (o_done && !o_result.last) |=> (o_done && o_result.last && o_result.line_done))

    // line number only reported with a completed line
    `VDHP_ASSERT_IMPLY(a_line_number_zero, i_clk, i_rst_n, o_done && !o_result.line_done, o_result.done_line_number == '0)

    // a taken interrupt comes from a take transaction: no data, no line
    `VDHP_ASSERT_IMPLY(a_taken_alone, i_clk, i_rst_n, o_done && o_result.interrupt_taken, o_result.read_value == 8'd0 && !o_result.line_done && o_result.last)

endmodule

bind video_display_host_port_and_line_timer vdhp_port_checker u_port_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_done   (o_done),
    .o_result (o_result)
);

@@ bench/tb.sv @@
// testbench for the video display host port and line timer
`timescale 1ns / 1ps
module tb;
    import vdhp_pkg::*;

    localparam int MEM_D   = MEMORY_DEPTH_DEF;
    localparam int CPL     = CYCLES_PER_LINE_DEF;
    localparam int VIS     = VISIBLE_LINES_DEF;
    localparam int TOT     = TOTAL_LINES_DEF;
    localparam int N_ITEMS = 1550;

    // spare kinds that the block ignores
    localparam logic [2:0] KIND_SPARE_6 = 3'd6;
    localparam logic [2:0] KIND_SPARE_7 = 3'd7;

    // predicts the host port results and checks them in order
    class host_port_scoreboard;
        logic [7:0]  vram [MEM_D];
        logic [7:0]  mode_reg [8];
        logic [13:0] vram_addr;
        logic [7:0]  cmd_latch;
        bit          second_pending;
        logic [7:0]  prefetch;
        logic [7:0]  status;
        bit          irq_pending;
        int unsigned line_cycles;
        int unsigned scan_line;
        t_out_item   pending_results[$];
        int unsigned n_items, n_results, n_lines, n_vblank, n_irqs, n_errors;

        function void clear_state();
            foreach (vram[i]) vram[i] = 8'h00;
            foreach (mode_reg[i]) mode_reg[i] = 8'h00;
            mode_reg[REG_IDX_ONE] = REG1_FORCE;
            vram_addr      = '0;
            cmd_latch      = '0;
            second_pending = 1'b0;
            prefetch       = '0;
            status         = '0;
            irq_pending    = 1'b0;
            line_cycles    = 0;
            scan_line      = 0;
        endfunction

        function void step_addr();
            vram_addr = vram_addr + 14'd1;
        endfunction

        // control port: byte pair sets a register or the access address
        function void ctrl_write(logic [7:0] b);
            logic [2:0] idx;
            if (!second_pending) begin
                cmd_latch      = b;
                second_pending = 1'b1;
                return;
            end
            second_pending = 1'b0;
            if (b[CMD_REG_BIT]) begin
                idx = b[2:0];
                if (idx == REG_IDX_ONE) begin
                    mode_reg[idx] = cmd_latch | REG1_FORCE;
                    if (mode_reg[idx][IRQ_EN_BIT] && status[VBLANK_BIT])
                        irq_pending = 1'b1;
                end else begin
                    mode_reg[idx] = cmd_latch;
                end
                return;
            end
            vram_addr = {b[5:0], cmd_latch};
            if (!b[CMD_NOPF_BIT]) begin
                prefetch = vram[vram_addr % MEM_D];
                step_addr();
            end
        endfunction

        // note an accepted transaction and queue the results it causes
        function void predict_results(t_in_item it);
            logic [7:0]        rd_val;
            bit                taken;
            int                nl;
            int                n;
            logic [LINE_W-1:0] done_line [2];
            t_out_item         r;
            rd_val = '0;
            taken  = 1'b0;
            nl     = 0;
            n_items++;
            case (it.kind)
                KIND_CTRL_WRITE: ctrl_write(it.port_byte);
                KIND_DATA_WRITE: begin
                    vram[vram_addr % MEM_D] = it.port_byte;
                    prefetch       = it.port_byte;
                    step_addr();
                    second_pending = 1'b0;
                end
                KIND_DATA_READ: begin
                    rd_val         = prefetch;
                    prefetch       = vram[vram_addr % MEM_D];
                    step_addr();
                    second_pending = 1'b0;
                end
                KIND_STATUS: begin
                    rd_val         = status;
                    status         = status & STATUS_KEEP;
                    second_pending = 1'b0;
                end
                KIND_TICK: begin
                    line_cycles += it.tick_cycles;
                    while (line_cycles >= CPL && nl < 2) begin
                        line_cycles -= CPL;
                        if (scan_line == VIS - 1) begin
                            status[VBLANK_BIT] = 1'b1;
                            n_vblank++;
                            if (mode_reg[REG_IDX_ONE][IRQ_EN_BIT])
                                irq_pending = 1'b1;
                        end
                        done_line[nl] = scan_line[LINE_W-1:0];
                        nl++;
                        scan_line++;
                        if (scan_line >= TOT)
                            scan_line = 0;
                    end
                end
                KIND_TAKE_IRQ: begin
                    taken       = irq_pending;
                    irq_pending = 1'b0;
                    if (taken)
                        n_irqs++;
                end
                default: ;
            endcase
            n = (nl > 0) ? nl : 1;
            n_lines += nl;
            for (int k = 0; k < n; k++) begin
                r                  = '0;
                r.read_value       = rd_val;
                r.interrupt_taken  = taken;
                r.interrupt_level  = irq_pending;
                r.line_done        = (nl > 0);
                r.done_line_number = (nl > 0) ? done_line[k] : '0;
                r.last             = (k == n - 1);
                pending_results.push_back(r);
            end
        endfunction

        function void field_check(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                n_errors++;
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, name, want, got);
            end
        endfunction

        // compare one result with the oldest expectation
        function void check_result(t_out_item got);
            t_out_item want;
            n_results++;
            if (pending_results.size() == 0) begin
                n_errors++;
                $display("%0t: unexpected result, expected none, actual %h", $time, got);
                return;
            end
            want = pending_results.pop_front();
            field_check("read_value", want.read_value, got.read_value);
            field_check("interrupt_taken", want.interrupt_taken, got.interrupt_taken);
            field_check("interrupt_level", want.interrupt_level, got.interrupt_level);
            field_check("line_done", want.line_done, got.line_done);
            field_check("done_line_number", want.done_line_number, got.done_line_number);
            field_check("last", want.last, got.last);
        endfunction
    endclass

    logic      i_clk;
    logic      i_rst_n;
    logic      start;
    logic      busy;
    t_in_item  i_item;
    logic      o_done;
    t_out_item o_result;

    host_port_scoreboard sb;
    bit sending;
    int burst_left;

    video_display_host_port_and_line_timer i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_item  (i_item),
        .o_done  (o_done),
        .o_result(o_result)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_done)
            sb.check_result(o_result);
    end

    function automatic t_in_item mk(logic [2:0] k, logic [7:0] pb, logic [7:0] tc);
        t_in_item it;
        it.kind        = k;
        it.port_byte   = pb;
        it.tick_cycles = tc;
        return it;
    endfunction

    task automatic lower_start();
        if (sending) begin
            start   <= 1'b0;
            sending  = 1'b0;
        end
    endtask

    // present one transaction, wait for acceptance, then maybe idle
    task automatic send(t_in_item it);
        start   <= 1'b1;
        i_item  <= it;
        sending  = 1'b1;
        do @(posedge i_clk); while (busy);
        sb.predict_results(it);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            lower_start();
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 24);
        end
    endtask

    task automatic send_pair(logic [7:0] b0, logic [7:0] b1);
        send(mk(KIND_CTRL_WRITE, b0, 8'($urandom)));
        send(mk(KIND_CTRL_WRITE, b1, 8'($urandom)));
    endtask

    task automatic drain();
        lower_start();
        while (sb.pending_results.size() != 0)
            @(posedge i_clk);
    endtask

    // run limit
    initial begin
        #5_000_000;
        $display("[video_display_host_port_and_line_timer] ERROR");
        $finish;
    end

    // stimulus
    initial begin
        int          sent;
        int          choice;
        bit          paused;
        logic [7:0]  lo;
        logic [5:0]  hi;
        logic [2:0]  idx;
        sb = new;
        sb.clear_state();
        sending    = 1'b0;
        burst_left = 10;
        paused     = 1'b0;
        sent       = 0;
        i_rst_n <= 1'b0;
        start   <= 1'b0;
        i_item  <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: status, irq enable, address wrap, prefetch, pair reset
        send(mk(KIND_STATUS, 8'h00, 8'h00));
        send_pair(8'h20, 8'h81);
        send_pair(8'hFF, 8'h7F);
        send(mk(KIND_DATA_WRITE, 8'hFF, 8'h00));
        send(mk(KIND_DATA_WRITE, 8'h00, 8'hFF));
        send(mk(KIND_DATA_WRITE, 8'hA5, 8'h00));
        send_pair(8'hFF, 8'h3F);
        send(mk(KIND_DATA_READ, 8'h00, 8'h00));
        send(mk(KIND_DATA_READ, 8'hFF, 8'hFF));
        send(mk(KIND_DATA_READ, 8'h00, 8'h00));
        send(mk(KIND_CTRL_WRITE, 8'h5A, 8'h00));
        send(mk(KIND_STATUS, 8'hFF, 8'hFF));
        send_pair(8'hFF, 8'h87);
        // line timer: no line, one line, no line, then two lines in one tick
        send(mk(KIND_TICK, 8'hFF, 8'h00));
        send(mk(KIND_TICK, 8'h00, 8'hFF));
        send(mk(KIND_TICK, 8'h00, 8'd200));
        send(mk(KIND_TICK, 8'h00, 8'hFF));
        send(mk(KIND_TAKE_IRQ, 8'hFF, 8'hFF));
        send(mk(KIND_SPARE_6, 8'hFF, 8'hFF));
        send(mk(KIND_SPARE_7, 8'h00, 8'h00));

        // random: mostly well-formed pairs, accesses and ticks
        while (sent < N_ITEMS) begin
            choice = $urandom_range(0, 99);
            if (choice < 18) begin
                // address set, mostly in a small window so reads hit writes
                lo = 8'($urandom);
                hi = ($urandom_range(0, 3) != 0) ? 6'($urandom_range(0, 3))
                                                 : 6'($urandom);
                send_pair(lo, {1'b0, 1'($urandom), hi});
                sent += 2;
            end else if (choice < 27) begin
                // register write, register one favored
                idx = ($urandom_range(0, 9) < 4) ? REG_IDX_ONE : 3'($urandom);
                send_pair(8'($urandom), {1'b1, 4'($urandom), idx});
                sent += 2;
            end else if (choice < 29) begin
                // lone first byte, pair broken by what follows
                send(mk(KIND_CTRL_WRITE, 8'($urandom), 8'($urandom)));
                sent++;
            end else if (choice < 43) begin
                send(mk(KIND_DATA_WRITE, 8'($urandom), 8'($urandom)));
                sent++;
            end else if (choice < 57) begin
                send(mk(KIND_DATA_READ, 8'($urandom), 8'($urandom)));
                sent++;
            end else if (choice < 64) begin
                send(mk(KIND_STATUS, 8'($urandom), 8'($urandom)));
                sent++;
            end else if (choice < 90) begin
                send(mk(KIND_TICK, 8'($urandom),
                        ($urandom_range(0, 9) < 7) ? 8'($urandom_range(150, 255))
                                                   : 8'($urandom)));
                sent++;
            end else if (choice < 98) begin
                send(mk(KIND_TAKE_IRQ, 8'($urandom), 8'($urandom)));
                sent++;
            end else begin
                send(mk(($urandom_range(0, 1) != 0) ? KIND_SPARE_6 : KIND_SPARE_7,
                        8'($urandom), 8'($urandom)));
            end
            // hold off once until everything outstanding has come back
            if (!paused && sent >= N_ITEMS / 2) begin
                drain();
                repeat ($urandom_range(2, 10)) @(posedge i_clk);
                paused = 1'b1;
            end
        end

        drain();
        repeat (10) @(posedge i_clk);
        $display("covered %0d transactions and %0d results: %0d lines reported,",
                 sb.n_items, sb.n_results, sb.n_lines);
        $display("%0d vblank entries, %0d interrupts taken", sb.n_vblank, sb.n_irqs);
        if (sb.n_errors == 0 && sb.pending_results.size() == 0) begin
            $display("[video_display_host_port_and_line_timer] OK");
        end else begin
            $display("[video_display_host_port_and_line_timer] ERROR");
        end
        $finish;
    end
endmodule
